### src/dttf_pkg.sv
package dttf_pkg;

	localparam int FRAC_W = 30;   // Kept fraction digits as an integer, up to 10^9 - 1.
	localparam int CNT_W  = 4;    // Count of kept fraction digits.
	localparam int VAL_W  = 64;   // Width of the fixed-point result port.

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_POINT = 8'h2E;

	localparam logic [3:0] DEC_BASE = 4'd10;

	typedef enum logic [1:0] {
		PH_INT  = 2'd0,
		PH_FRAC = 2'd1,
		PH_STOP = 2'd2
	} phase_t;

	// Power of ten that divides the kept fraction digits; counts above nine use 10^9.
	function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] idx);
		logic [FRAC_W-1:0] p;
		case (idx)
			4'd0: p = 30'd1;
			4'd1: p = 30'd10;
			4'd2: p = 30'd100;
			4'd3: p = 30'd1000;
			4'd4: p = 30'd10000;
			4'd5: p = 30'd100000;
			4'd6: p = 30'd1000000;
			4'd7: p = 30'd10000000;
			4'd8: p = 30'd100000000;
			default: p = 30'd1000000000;
		endcase
		return p;
	endfunction

endpackage

### src/dttf_div.sv
module dttf_div import dttf_pkg::*; #(
	parameter int QUO_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [FRAC_W-1:0]   numer,
	input  logic [FRAC_W-1:0]   denom,
	output logic                done,
	output logic [QUO_BITS-1:0] quotient
);

	localparam int STEP_W = $clog2(QUO_BITS + 1);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [FRAC_W-1:0]   rem_q;
	logic [FRAC_W-1:0]   den_q;
	logic [QUO_BITS-1:0] quo_q;

	logic [FRAC_W:0]     shifted;
	logic [FRAC_W:0]     diff;
	logic                fits;

	// The remainder always stays below the divisor, so doubling it needs one extra bit.
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(QUO_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= fits ? diff[FRAC_W-1:0] : shifted[FRAC_W-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### src/decimal_text_to_fixed.sv
// Parses an unsigned ASCII decimal number that arrives one character per item and
// returns it in unsigned fixed point, integer part from bit FRAC_BITS up and fraction
// below; bits above INT_BITS + FRAC_BITS read as zero. Integer digits saturate at
// 2^INT_BITS - 1 and raise int_overflow; fraction digits past MAX_FRAC_DIGITS are
// dropped. Parsing stops at the first character that does not fit the form, and one
// result comes out for each item marked last_char. An item marked last starts a
// restoring divider that produces one fraction bit per cycle, so char_ready stays low
// until the result is loaded into the output register, which waits while the previous
// result has not been taken yet. Characters of the next string are accepted while a
// finished result waits in the output register.
module decimal_text_to_fixed import dttf_pkg::*; #(
	parameter int INT_BITS        = 32,
	parameter int FRAC_BITS       = 32,
	parameter int MAX_FRAC_DIGITS = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_ready,
	input  logic [7:0]       char_byte,
	input  logic             last_char,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [VAL_W-1:0] value_fixed,
	output logic             int_overflow,
	output logic             had_point
);

	localparam int IW4 = INT_BITS + 4;

	phase_t              phase_q, phase_d;
	logic [INT_BITS-1:0] int_q, int_d;
	logic [FRAC_W-1:0]   frac_q, frac_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                ovf_q, ovf_d;
	logic                pt_q, pt_d;

	logic                job_q;
	logic                pend_q;
	logic [INT_BITS-1:0] int_hold_q;
	logic                ovf_hold_q;
	logic                pt_hold_q;

	logic                res_valid_q;
	logic [VAL_W-1:0]    value_q;
	logic                res_ovf_q;
	logic                res_pt_q;

	logic                take;
	logic                is_digit;
	logic [3:0]          digit;
	logic [IW4-1:0]      int_times10;
	logic                div_start;
	logic                div_done;
	logic [FRAC_BITS-1:0] quo;
	logic                load_out;

	assign char_ready = !job_q;
	assign take       = char_valid && char_ready;
	assign is_digit   = char_byte inside {[CHAR_ZERO:CHAR_NINE]};
	assign digit      = char_byte[3:0];
	assign int_times10 = (IW4'(int_q) << 3) + (IW4'(int_q) << 1) + IW4'(digit);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_INT: begin
				if (!is_digit)
					phase_d = (char_byte == CHAR_POINT) ? PH_FRAC : PH_STOP;
			end
			PH_FRAC: begin
				if (!is_digit)
					phase_d = PH_STOP;
			end
			default: phase_d = PH_STOP;
		endcase
	end

	always_comb begin
		int_d  = int_q;
		frac_d = frac_q;
		cnt_d  = cnt_q;
		ovf_d  = ovf_q;
		pt_d   = pt_q;
		case (phase_q)
			PH_INT: begin
				if (is_digit) begin
					if (int_times10[IW4-1:INT_BITS] != '0) begin
						int_d = '1;
						ovf_d = 1'b1;
					end else begin
						int_d = int_times10[INT_BITS-1:0];
					end
				end else if (char_byte == CHAR_POINT) begin
					pt_d = 1'b1;
				end
			end
			PH_FRAC: begin
				if (is_digit && cnt_q < CNT_W'(MAX_FRAC_DIGITS)) begin
					frac_d = FRAC_W'(frac_q * DEC_BASE) + FRAC_W'(digit);
					cnt_d  = cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign div_start = take && last_char;
	assign load_out  = pend_q && (!res_valid_q || result_ready);

	dttf_div #(
		.QUO_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (frac_d),
		.denom    (pow10(cnt_d)),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INT;
			int_q       <= '0;
			frac_q      <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			pt_q        <= 1'b0;
			job_q       <= 1'b0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (last_char) begin
					phase_q <= PH_INT;
					int_q   <= '0;
					frac_q  <= '0;
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					pt_q    <= 1'b0;
					job_q   <= 1'b1;
				end else begin
					phase_q <= phase_d;
					int_q   <= int_d;
					frac_q  <= frac_d;
					cnt_q   <= cnt_d;
					ovf_q   <= ovf_d;
					pt_q    <= pt_d;
				end
			end
			if (div_done)
				pend_q <= 1'b1;
			if (load_out) begin
				pend_q      <= 1'b0;
				job_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			int_hold_q <= int_d;
			ovf_hold_q <= ovf_d;
			pt_hold_q  <= pt_d;
		end
		if (load_out) begin
			value_q   <= VAL_W'({int_hold_q, quo});
			res_ovf_q <= ovf_hold_q;
			res_pt_q  <= pt_hold_q;
		end
	end

	assign result_valid = res_valid_q;
	assign value_fixed  = value_q;
	assign int_overflow = res_ovf_q;
	assign had_point    = res_pt_q;

endmodule
